[hw/rtl/afca_pkg.sv]
// Shared constants, types and command/status bundles for the ADC frame capture averager.
`default_nettype none

package afca_pkg;

  // Field and accumulator widths
  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int TIME_BITS   = 16;
  localparam int SUM_BITS    = 40;
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int ITER_BITS   = $clog2(DIV_STEPS);

  // Configuration
  localparam int CFG_ADDR_BITS = 3;
  localparam logic [TIME_BITS-1:0] WINDOW_RESET = TIME_BITS'(5);
  localparam logic REG_WINDOW = 1'b0;

  // Request kinds carried on in_tuser
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } afca_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic edge_take;
    logic read_start;
    logic div_step;
    logic out_load;
  } afca_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic total_zero;
    logic out_free;
  } afca_sts_t;

endpackage

`default_nettype wire

[hw/rtl/afca_ctrl.sv]
// Controller state machine: request intake, divide sequencing and result hand-off.
`default_nettype none

module afca_ctrl
  import afca_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_cmd,
  output logic            in_ready,
  input  wire afca_sts_t  sts,
  output afca_cmd_t       cmd
);

  afca_state_t           state_r, state_nxt;
  logic [ITER_BITS-1:0]  iter_r, iter_nxt;

  // Hold state and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // Decode next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_EDGE) begin
            cmd.edge_take = 1'b1;
          end else begin
            cmd.read_start = 1'b1;
            iter_nxt       = '0;
            state_nxt      = sts.total_zero ? ST_FIN : ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + ITER_BITS'(1);
        if (iter_r == ITER_BITS'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/afca_dp.sv]
// Datapath: edge gap check, running sum, serial restoring divider and result register.
`default_nettype none

module afca_dp
  import afca_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire afca_cmd_t                    cmd,
  output afca_sts_t                         sts,
  input  wire logic [TIME_BITS-1:0]         in_time,
  input  wire logic [SAMPLE_BITS-1:0]       in_word,
  input  wire logic [TIME_BITS-1:0]         window,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic signed [SAMPLE_BITS-1:0]     out_avg,
  output logic [COUNT_BITS-1:0]             out_cnt,
  output logic                              out_empty,
  output logic                              out_ovf
);

  // Accumulator state
  logic [TIME_BITS-1:0]        last_r;
  logic signed [SUM_BITS-1:0]  sum_r;
  logic [COUNT_BITS-1:0]       total_r;
  logic                        drop_r;

  // Divider state
  logic [SUM_BITS-1:0]         dvd_r;
  logic [COUNT_BITS-1:0]       rem_r;
  logic [COUNT_BITS-1:0]       dvs_r;
  logic                        neg_r;
  logic                        empty_r;
  logic                        drop_snap_r;

  // Result register
  logic                        out_valid_r;
  logic [SAMPLE_BITS-1:0]      out_avg_r;
  logic [COUNT_BITS-1:0]       out_cnt_r;
  logic                        out_empty_r;
  logic                        out_ovf_r;

  logic [TIME_BITS-1:0]        gap;
  logic                        in_window;
  logic signed [SUM_BITS-1:0]  sample_ext;
  logic [SUM_BITS-1:0]         sum_mag;
  logic [COUNT_BITS:0]         shifted;
  logic [COUNT_BITS+1:0]       trial;
  logic                        qbit;
  logic [SAMPLE_BITS-1:0]      q_mag;
  logic [SAMPLE_BITS-1:0]      q_signed;

  // Gap since previous edge, wrapping at the timestamp width
  assign gap        = in_time - last_r;
  assign in_window  = gap < window;
  assign sample_ext = {{(SUM_BITS-SAMPLE_BITS){in_word[SAMPLE_BITS-1]}}, in_word};
  assign sum_mag    = sum_r[SUM_BITS-1] ? SUM_BITS'(-sum_r) : SUM_BITS'(sum_r);

  // One restoring divide step: shift in the next dividend bit, try to subtract
  assign shifted = {rem_r, dvd_r[SUM_BITS-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign qbit    = !trial[COUNT_BITS+1];

  // Quotient fits the sample width; apply sign of the sum
  assign q_mag    = dvd_r[SAMPLE_BITS-1:0];
  assign q_signed = neg_r ? SAMPLE_BITS'(-q_mag) : q_mag;

  assign sts = '{total_zero: (total_r == '0), out_free: (!out_valid_r || out_ready)};

  // Accumulate edges, clear on read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      sum_r   <= '0;
      total_r <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.edge_take) begin
      last_r <= in_time;
      if (in_window) begin
        if (total_r == '1) begin
          drop_r <= 1'b1;
        end else begin
          sum_r   <= sum_r + sample_ext;
          total_r <= total_r + COUNT_BITS'(1);
        end
      end
    end else if (cmd.read_start) begin
      sum_r   <= '0;
      total_r <= '0;
      drop_r  <= 1'b0;
    end
  end

  // Snapshot the sum on read, then run the divide one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.read_start) begin
      dvd_r       <= sum_mag;
      rem_r       <= '0;
      dvs_r       <= total_r;
      neg_r       <= sum_r[SUM_BITS-1];
      empty_r     <= (total_r == '0);
      drop_snap_r <= drop_r;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[SUM_BITS-2:0], qbit};
      rem_r <= qbit ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
    end
  end

  // Result valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_avg_r   <= empty_r ? '0 : q_signed;
      out_cnt_r   <= empty_r ? '0 : dvs_r;
      out_empty_r <= empty_r;
      out_ovf_r   <= drop_snap_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_avg   = out_avg_r;
  assign out_cnt   = out_cnt_r;
  assign out_empty = out_empty_r;
  assign out_ovf   = out_ovf_r;

endmodule

`default_nettype wire

[hw/rtl/adc_frame_capture_averager.sv]
// ADC frame capture averager: stream ports, window register, controller and datapath.
//
// Input stream: in_tuser picks the request kind (edge event or read request);
// in_tdata carries the edge timestamp and the 24-bit serial frame word.
// An edge request yields no result; edges are accepted back to back while the
// block is idle. An edge whose gap from the previous edge is below pair_window_us
// adds its sign-extended word to the running sum, or sets the overflow flag if
// the count is full. A read request yields one result: sum / count truncated
// toward zero, the count, a no-samples flag and an overflow flag; sum, count
// and flag clear. A read with a nonzero count runs a 40-step restoring divide,
// one quotient bit per cycle, and no new request is taken until its result is
// loaded; a read with a zero count skips the divide. The result then waits in
// an output register; if the receiver stalls, the block holds in its final step
// with in_tready low until that register frees up.
// The window register sits on an APB port at byte address 0 (reset value 5);
// write it only while no request is in progress.
// Reset (synchronous, rst_n low) clears the last edge time, sum, count,
// drop flag and any pending result.
`default_nettype none

module adc_frame_capture_averager
  import afca_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Input request stream
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [39:0]               in_tdata,   // [15:0] time_us, [39:16] data_word
  input  wire logic                      in_tuser,   // [0] cmd
  // Result stream
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [39:0]                    out_tdata,  // [23:0] average, [39:24] sample_count
  output logic [1:0]                     out_tuser,  // [0] no_samples, [1] overflowed
  // Configuration port
  input  wire logic                      cfg_psel,
  input  wire logic                      cfg_penable,
  input  wire logic                      cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [31:0]               cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic [TIME_BITS-1:0]          window_r;
  logic                          cfg_wr;
  afca_cmd_t                     cmd;
  afca_sts_t                     sts;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic [COUNT_BITS-1:0]         cnt;
  logic                          empty;
  logic                          ovf;

  // Window register write on the APB access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr && (cfg_paddr[CFG_ADDR_BITS-1] == REG_WINDOW)) begin
      window_r <= cfg_pwdata[TIME_BITS-1:0];
    end
  end

  // Read back the window register, zero elsewhere
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_BITS-1] == REG_WINDOW) begin
      cfg_prdata = {{(32-TIME_BITS){1'b0}}, window_r};
    end
  end

  afca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  afca_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_time   (in_tdata[TIME_BITS-1:0]),
    .in_word   (in_tdata[TIME_BITS+SAMPLE_BITS-1:TIME_BITS]),
    .window    (window_r),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_avg   (avg),
    .out_cnt   (cnt),
    .out_empty (empty),
    .out_ovf   (ovf)
  );

  // Pack result fields
  assign out_tdata = {cnt, avg};
  assign out_tuser = {ovf, empty};

  // A read request clears the count on the next edge
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_READ)) |=> sts.total_zero)
    else $error("count not cleared after read request");

  // The block is busy right after taking a read request
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_READ)) |=> !in_tready)
    else $error("request accepted during read processing");

  // An empty read reports zero average and zero count
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("empty read with nonzero payload");

endmodule

`default_nettype wire
